// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

// ===== sv/lzssw_pkg.sv =====
`default_nettype none
package lzssw_pkg;

   localparam int WIN_AW = 12;
   localparam int LANES  = 8;

   localparam logic [2:0] PH_FLAG    = 3'd0;
   localparam logic [2:0] PH_LIT     = 3'd1;
   localparam logic [2:0] PH_TOK_LO  = 3'd2;
   localparam logic [2:0] PH_TOK_HI  = 3'd3;
   localparam logic [2:0] PH_RUN_VAL = 3'd4;

   localparam logic [WIN_AW-1:0] WP_PLAIN = 12'd4078;
   localparam logic [WIN_AW-1:0] WP_EXT   = 12'd4079;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte_0;
      logic [7:0] out_byte_1;
      logic [7:0] out_byte_2;
      logic [7:0] out_byte_3;
      logic [7:0] out_byte_4;
      logic [7:0] out_byte_5;
      logic [7:0] out_byte_6;
      logic [7:0] out_byte_7;
      logic [3:0] byte_count;
      logic       run_last;
      logic       stream_done;
   } rsp_type;

   typedef struct packed {
      logic              we;
      logic [WIN_AW-1:0] waddr;
      logic [7:0]        wdata;
      logic              re;
      logic [WIN_AW-1:0] raddr;
   } win_req_type;

endpackage
`default_nettype wire

// ===== sv/lzss_window_rle_decoder.sv =====
// LZSS decoder with a 4096-byte history window and optional run tokens. One
// compressed byte is taken per req_ transfer; the decoded bytes leave on the
// rsp_ channel in groups of up to eight, the last group of each input byte
// marked run_last, and stream_done set on it when the byte closed the stream.
// A byte that decodes nothing sends no group, but one that carries
// stream_end still sends its empty final group through the flush state. A
// byte that decodes bytes writes each run or literal byte into the window,
// and reads each copied byte from the window and writes it back before the
// next read, then flushes its final group. A full group of eight stalls the
// decoding until it drains, and any group held back by rsp_ready stalls it
// too. After reset, after a csr_ write and after a stream_end byte, the
// window is preset by a sweep over all 4096 entries that writes one entry
// per cycle; req_ready stays low until that sweep has finished.
// extended_mode is written via csr_we/csr_wdata; the user must write it only
// while the block is idle, as the block itself does not enforce this.
`default_nettype none
`include "assert_macros.svh"
module lzss_window_rle_decoder (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  lzssw_pkg::req_type req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output lzssw_pkg::rsp_type rsp_data,
   input  wire                csr_we,
   input  wire                csr_wdata
);
   import lzssw_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PRESET = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_WRITE  = 3'd3;
   localparam logic [2:0] S_FLUSH  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic              mode_ff, mode_in;
   logic [WIN_AW-1:0] wp_ff, wp_in;
   logic [8:0]        flag_ff, flag_in;
   logic [2:0]        phase_ff, phase_in;
   logic [7:0]        off_lo_ff, off_lo_in;
   logic [7:0]        off_held_ff, off_held_in;
   logic [WIN_AW-1:0] src_ff, src_in;
   logic [8:0]        rem_ff, rem_in;
   logic              copy_ff, copy_in;
   logic [7:0]        val_ff, val_in;
   logic              end_ff, end_in;
   logic [7:0]        grp_ff [LANES];
   logic [3:0]        grp_cnt_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   win_req_type       win_req;
   logic              preset_go;
   logic              preset_busy;
   logic [7:0]        rdata;

   logic              accept;
   logic [8:0]        fs;
   logic [2:0]        next_phase;
   logic [WIN_AW-1:0] tok_off;
   logic              out_free;
   logic              full_push;
   logic              last_push;
   logic              add_en;
   logic [7:0]        add_byte;

   lzssw_window u_window (
      .clock      (clock),
      .reset      (reset),
      .win_req    (win_req),
      .preset_go  (preset_go),
      .preset_busy(preset_busy),
      .rdata      (rdata)
   );

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   // advance to the next token of the flag byte
   assign fs         = flag_ff >> 1;
   assign next_phase = (fs <= 9'd1) ? PH_FLAG : (fs[0] ? PH_LIT : PH_TOK_LO);
   assign tok_off    = {req_data.data_byte[7:4], off_lo_ff};

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign full_push = (state_ff != S_FLUSH) && (grp_cnt_ff == 4'd8) && out_free;
   assign last_push = (state_ff == S_FLUSH) && out_free;
   assign add_en    = (state_ff == S_WRITE) && (grp_cnt_ff < 4'd8);
   assign add_byte  = copy_ff ? rdata : val_ff;

   always_comb begin
      win_req       = '0;
      win_req.re    = (state_ff == S_READ);
      win_req.raddr = src_ff;
      win_req.we    = add_en;
      win_req.waddr = wp_ff;
      win_req.wdata = add_byte;
   end

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      wp_in       = wp_ff;
      flag_in     = flag_ff;
      phase_in    = phase_ff;
      off_lo_in   = off_lo_ff;
      off_held_in = off_held_ff;
      src_in      = src_ff;
      rem_in      = rem_ff;
      copy_in     = copy_ff;
      val_in      = val_ff;
      end_in      = end_ff;
      preset_go   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               end_in   = req_data.stream_end;
               state_in = req_data.stream_end ? S_FLUSH : S_IDLE;
               case (phase_ff)
                  PH_LIT: begin
                     copy_in  = 1'b0;
                     val_in   = req_data.data_byte;
                     rem_in   = 9'd1;
                     phase_in = next_phase;
                     flag_in  = fs;
                     state_in = S_WRITE;
                  end
                  PH_TOK_LO: begin
                     off_lo_in = req_data.data_byte;
                     phase_in  = PH_TOK_HI;
                  end
                  PH_TOK_HI: begin
                     if (!mode_ff || req_data.data_byte[3:0] != 4'hF) begin
                        copy_in  = 1'b1;
                        src_in   = tok_off;
                        rem_in   = {5'd0, req_data.data_byte[3:0]} + 9'd3;
                        phase_in = next_phase;
                        flag_in  = fs;
                        state_in = S_READ;
                     end else if (tok_off[11:8] == 4'd0) begin
                        off_held_in = tok_off[7:0];
                        phase_in    = PH_RUN_VAL;
                     end else begin
                        copy_in  = 1'b0;
                        val_in   = tok_off[7:0];
                        rem_in   = {5'd0, tok_off[11:8]} + 9'd3;
                        phase_in = next_phase;
                        flag_in  = fs;
                        state_in = S_WRITE;
                     end
                  end
                  PH_RUN_VAL: begin
                     copy_in  = 1'b0;
                     val_in   = req_data.data_byte;
                     rem_in   = {1'b0, off_held_ff} + 9'd19;
                     phase_in = next_phase;
                     flag_in  = fs;
                     state_in = S_WRITE;
                  end
                  default: begin
                     flag_in  = {1'b1, req_data.data_byte};
                     phase_in = req_data.data_byte[0] ? PH_LIT : PH_TOK_LO;
                  end
               endcase
            end
         end
         S_PRESET: begin
            if (!preset_busy) state_in = S_IDLE;
         end
         S_READ: begin
            if (grp_cnt_ff < 4'd8) begin
               src_in   = src_ff + 1'b1;
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (add_en) begin
               wp_in  = wp_ff + 1'b1;
               rem_in = rem_ff - 1'b1;
               if (rem_ff == 9'd1) state_in = S_FLUSH;
               else state_in = copy_ff ? S_READ : S_WRITE;
            end
         end
         S_FLUSH: begin
            if (out_free) state_in = end_ff ? S_PRESET : S_IDLE;
            if (out_free && end_ff) preset_go = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase

      // restart: take the mode on a csr_ write, preset window, reset write position and parser
      if (preset_go || csr_we) begin
         if (csr_we) mode_in = csr_wdata;
         preset_go   = 1'b1;
         state_in    = S_PRESET;
         wp_in       = (csr_we ? csr_wdata : mode_ff) ? WP_EXT : WP_PLAIN;
         flag_in     = '0;
         phase_in    = PH_FLAG;
         off_lo_in   = '0;
         off_held_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_PRESET;
         mode_ff      <= 1'b0;
         wp_ff        <= WP_PLAIN;
         flag_ff      <= '0;
         phase_ff     <= PH_FLAG;
         off_lo_ff    <= '0;
         off_held_ff  <= '0;
         grp_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         end_ff       <= 1'b0;
         for (int i = 0; i < LANES; i++) grp_ff[i] <= '0;
      end else begin
         state_ff    <= state_in;
         mode_ff     <= mode_in;
         wp_ff       <= wp_in;
         flag_ff     <= flag_in;
         phase_ff    <= phase_in;
         off_lo_ff   <= off_lo_in;
         off_held_ff <= off_held_in;
         end_ff      <= end_in;
         // group buffer: drain a full or final group, else collect a byte
         if (full_push || last_push) begin
            grp_cnt_ff <= '0;
            for (int i = 0; i < LANES; i++) grp_ff[i] <= '0;
         end else if (add_en) begin
            grp_ff[grp_cnt_ff[2:0]] <= add_byte;
            grp_cnt_ff              <= grp_cnt_ff + 1'b1;
         end
         if (full_push || last_push) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      src_ff  <= src_in;
      rem_ff  <= rem_in;
      copy_ff <= copy_in;
      val_ff  <= val_in;
      if (full_push || last_push) begin
         rsp_data_ff.out_byte_0  <= grp_ff[0];
         rsp_data_ff.out_byte_1  <= grp_ff[1];
         rsp_data_ff.out_byte_2  <= grp_ff[2];
         rsp_data_ff.out_byte_3  <= grp_ff[3];
         rsp_data_ff.out_byte_4  <= grp_ff[4];
         rsp_data_ff.out_byte_5  <= grp_ff[5];
         rsp_data_ff.out_byte_6  <= grp_ff[6];
         rsp_data_ff.out_byte_7  <= grp_ff[7];
         rsp_data_ff.byte_count  <= grp_cnt_ff;
         rsp_data_ff.run_last    <= last_push;
         rsp_data_ff.stream_done <= last_push && end_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_CLK(a_idle_empty, clock, reset, req_ready |-> (grp_cnt_ff == 4'd0))
   `ASSERT_CLK(a_mid_group_full, clock, reset,
      (rsp_valid && !rsp_data.run_last) |-> (rsp_data.byte_count == 4'd8))
   `ASSERT_CLK(a_done_is_last, clock, reset,
      (rsp_valid && rsp_data.stream_done) |-> rsp_data.run_last)

endmodule
`default_nettype wire

// ===== sv/lzssw_window.sv =====
`default_nettype none
`include "assert_macros.svh"
module lzssw_window (
   input  wire                  clock,
   input  wire                  reset,
   input  lzssw_pkg::win_req_type win_req,
   input  wire                  preset_go,
   output logic                 preset_busy,
   output logic [7:0]           rdata
);
   import lzssw_pkg::*;

   logic [7:0]        mem [2**WIN_AW];
   logic              busy_ff, busy_in;
   logic [WIN_AW-1:0] pa_ff, pa_in;
   logic [7:0]        pn_ff, pn_in;
   logic [2:0]        pr_ff, pr_in;
   logic [7:0]        pval;
   logic              we;
   logic [WIN_AW-1:0] waddr;
   logic [7:0]        wdata;

   // preset pattern, generated in address order
   always_comb begin
      if (!pa_ff[WIN_AW-1]) begin
         pval = pa_ff[0] ? 8'h00 : pa_ff[10:3];
      end else if (pa_ff[WIN_AW-1:8] != 4'hF) begin
         pval = pr_ff[0] ? 8'hFF : pn_ff;
      end else begin
         pval = 8'h00;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      pa_in   = pa_ff;
      pn_in   = pn_ff;
      pr_in   = pr_ff;
      if (preset_go) begin
         busy_in = 1'b1;
         pa_in   = '0;
         pn_in   = '0;
         pr_in   = '0;
      end else if (busy_ff) begin
         pa_in = pa_ff + 1'b1;
         if (pa_ff == {WIN_AW{1'b1}}) busy_in = 1'b0;
         if (pa_ff[WIN_AW-1]) begin
            if (pr_ff == 3'd6) begin
               pr_in = '0;
               pn_in = pn_ff + 1'b1;
            end else begin
               pr_in = pr_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         pa_ff   <= '0;
         pn_ff   <= '0;
         pr_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         pa_ff   <= pa_in;
         pn_ff   <= pn_in;
         pr_ff   <= pr_in;
      end
   end

   assign we    = busy_ff ? 1'b1 : win_req.we;
   assign waddr = busy_ff ? pa_ff : win_req.waddr;
   assign wdata = busy_ff ? pval : win_req.wdata;

   always_ff @(posedge clock) begin
      if (we && !preset_go) mem[waddr] <= wdata;
      if (win_req.re) rdata <= mem[win_req.raddr];
   end

   assign preset_busy = busy_ff;

   `ASSERT_NEVER(a_no_access_in_preset, clock, reset, busy_ff && (win_req.we || win_req.re))
   `ASSERT_CLK(a_sweep_ends, clock, reset,
      (busy_ff && !preset_go && pa_ff == {WIN_AW{1'b1}}) |=> !busy_ff)
   `ASSERT_CLK(a_go_starts, clock, reset, preset_go |=> (busy_ff && pa_ff == '0))

endmodule
`default_nettype wire
